>>> src/mrq_pkg.sv
package mrq_pkg;

    // Result status codes
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_FULL      = 3'd1;
    localparam logic [2:0] ST_EMPTY     = 3'd2;
    localparam logic [2:0] ST_TOO_SMALL = 3'd3;
    localparam logic [2:0] ST_TOO_LONG  = 3'd4;

    // Request and reply kinds
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    // Controller to datapath
    typedef struct packed {
        logic push;       // accept one pushed byte
        logic pop_empty;  // accept a pop on an empty queue, emit empty reply
        logic pop_check;  // accept a pop, read head length, hold capacity
        logic too_small;  // emit too_small reply
        logic pop_start;  // advance head, set up byte stream
        logic rd_issue;   // read next byte of the popped slot
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic empty;       // head equals tail
        logic len_gt_cap;  // stored length exceeds held capacity
        logic rd_pending;  // read data waits for the output register
        logic out_free;    // output register can load this cycle
        logic issue_last;  // next byte read is the final one
    } t_stat;

endpackage

>>> src/mrq_ctrl.sv
module mrq_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    input  logic          i_kind,
    input  mrq_pkg::t_stat i_stat,
    output logic          o_s_tready,
    output mrq_pkg::t_cmd o_cmd
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_LEN    = 2'd1;
    localparam logic [1:0] S_STREAM = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       accept;

    assign o_s_tready = (r_state == S_IDLE) && i_stat.out_free && !i_stat.rd_pending;
    assign accept     = i_s_tvalid && o_s_tready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_kind == mrq_pkg::KIND_PUSH) begin
                        o_cmd.push = 1'b1;
                    end else if (i_stat.empty) begin
                        o_cmd.pop_empty = 1'b1;
                    end else begin
                        o_cmd.pop_check = 1'b1;
                        n_state         = S_LEN;
                    end
                end
            end
            S_LEN: begin
                if (i_stat.len_gt_cap) begin
                    // hold until the reply can be loaded
                    if (i_stat.out_free) begin
                        o_cmd.too_small = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    o_cmd.pop_start = 1'b1;
                    n_state         = S_STREAM;
                end
            end
            S_STREAM: begin
                if (!i_stat.rd_pending || i_stat.out_free) begin
                    o_cmd.rd_issue = 1'b1;
                    if (i_stat.issue_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/mrq_dpath.sv
module mrq_dpath #(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  mrq_pkg::t_cmd  i_cmd,
    output mrq_pkg::t_stat o_stat,
    input  logic [7:0]     i_data_byte,
    input  logic           i_last_byte,
    input  logic [7:0]     i_capacity,
    input  logic           i_m_tready,
    output logic           o_m_tvalid,
    output logic [23:0]    o_m_tdata,  // status[2:0], out_byte[10:3], message_length[16:11],
                                       // not_empty[17], zero[23:18]
    output logic           o_m_tuser,  // reply_kind
    output logic           o_m_tlast   // last_out
);

    localparam int SW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOT_BYTES + 1);
    localparam int AW = $clog2(SLOTS * SLOT_BYTES);

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] p);
        logic [SW-1:0] q;
        q = (p == SW'(SLOTS - 1)) ? '0 : p + SW'(1);
        return q;
    endfunction

    logic [7:0]    byte_mem [SLOTS*SLOT_BYTES];
    logic [CW-1:0] len_mem  [SLOTS];

    logic [SW-1:0] r_head, n_head;
    logic [SW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count;
    logic          r_drop;
    logic [CW-1:0] r_len;
    logic [7:0]    r_cap;
    logic [SW-1:0] r_pop_slot;
    logic [CW-1:0] r_i;
    logic [CW-1:0] r_n;
    logic [7:0]    r_rd_byte;
    logic          r_rd_zero;
    logic          r_rd_last;
    logic          r_rd_v;

    logic          r_o_valid;
    logic [2:0]    r_o_status;
    logic [7:0]    r_o_byte;
    logic [5:0]    r_o_len;
    logic          r_o_ne;
    logic          r_o_kind;
    logic          r_o_last;

    logic          out_free;
    logic          store;
    logic          drop_now;
    logic          full;
    logic          push_ack;
    logic          commit;
    logic          load_rd;
    logic          load_out;
    logic [2:0]    push_status;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr;
    logic [CW-1:0] n_bytes;
    logic [CW+5:0] len_ext;

    assign out_free = !r_o_valid || i_m_tready;
    assign store    = i_cmd.push && (r_count < CW'(SLOT_BYTES));
    assign drop_now = r_drop || (i_cmd.push && !store);
    assign full     = (next_slot(r_tail) == r_head);
    assign push_ack = i_cmd.push && i_last_byte;
    assign commit   = push_ack && !drop_now && !full;
    assign load_rd  = r_rd_v && out_free;
    assign load_out = push_ack || i_cmd.pop_empty || i_cmd.too_small || load_rd;

    assign push_status = drop_now ? mrq_pkg::ST_TOO_LONG :
                         full     ? mrq_pkg::ST_FULL     : mrq_pkg::ST_OK;

    assign waddr   = AW'(r_tail) * AW'(SLOT_BYTES) + AW'(r_count);
    assign raddr   = AW'(r_pop_slot) * AW'(SLOT_BYTES) + AW'(r_i);
    assign n_bytes = ({1'b0, r_cap} < 9'(SLOT_BYTES)) ? r_cap[CW-1:0] : CW'(SLOT_BYTES);
    assign len_ext = {6'd0, r_len};

    assign n_head = i_cmd.pop_start ? next_slot(r_head) : r_head;
    assign n_tail = commit ? next_slot(r_tail) : r_tail;

    assign o_stat.empty      = (r_head == r_tail);
    assign o_stat.len_gt_cap = ({{(8-CW){1'b0}}, r_len} > r_cap);
    assign o_stat.rd_pending = r_rd_v;
    assign o_stat.out_free   = out_free;
    assign o_stat.issue_last = ((r_i + CW'(1)) == r_n);

    // storage
    always_ff @(posedge i_clk) begin
        if (store) begin
            byte_mem[waddr] <= i_data_byte;
        end
        if (commit) begin
            len_mem[r_tail] <= r_count + CW'(1);
        end
        if (i_cmd.pop_check) begin
            r_len <= len_mem[r_head];
            r_cap <= i_capacity;
        end
        if (i_cmd.rd_issue) begin
            r_rd_byte <= byte_mem[raddr];
            r_rd_zero <= (r_i >= r_len);
            r_rd_last <= ((r_i + CW'(1)) == r_n);
        end
        if (i_cmd.pop_start) begin
            r_pop_slot <= r_head;
            r_n        <= n_bytes;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= '0;
            r_tail    <= '0;
            r_count   <= '0;
            r_drop    <= 1'b0;
            r_i       <= '0;
            r_rd_v    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_head <= n_head;
            r_tail <= n_tail;
            if (push_ack) begin
                r_count <= '0;
                r_drop  <= 1'b0;
            end else begin
                if (store) begin
                    r_count <= r_count + CW'(1);
                end
                if (i_cmd.push && !store) begin
                    r_drop <= 1'b1;
                end
            end
            if (i_cmd.pop_start) begin
                r_i <= '0;
            end else if (i_cmd.rd_issue) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.rd_issue) begin
                r_rd_v <= 1'b1;
            end else if (load_rd) begin
                r_rd_v <= 1'b0;
            end
            if (load_out) begin
                r_o_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // output register payload
    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_ne <= (n_head != n_tail);
            if (push_ack) begin
                r_o_kind   <= mrq_pkg::KIND_PUSH;
                r_o_status <= push_status;
                r_o_byte   <= 8'd0;
                r_o_len    <= 6'd0;
                r_o_last   <= 1'b1;
            end else if (i_cmd.pop_empty || i_cmd.too_small) begin
                r_o_kind   <= mrq_pkg::KIND_POP;
                r_o_status <= i_cmd.pop_empty ? mrq_pkg::ST_EMPTY : mrq_pkg::ST_TOO_SMALL;
                r_o_byte   <= 8'd0;
                r_o_len    <= 6'd0;
                r_o_last   <= 1'b1;
            end else begin
                r_o_kind   <= mrq_pkg::KIND_POP;
                r_o_status <= mrq_pkg::ST_OK;
                r_o_byte   <= r_rd_zero ? 8'd0 : r_rd_byte;
                r_o_len    <= len_ext[5:0];
                r_o_last   <= r_rd_last;
            end
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = {6'd0, r_o_ne, r_o_len, r_o_byte, r_o_status};
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load_out |-> (!r_o_valid || i_m_tready))
        else $error("output register loaded while a result is stalled");

    a_read_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (r_i < r_n))
        else $error("byte read past the popped length");

    a_commit_non_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit |=> (r_head != r_tail))
        else $error("committed push left the queue empty");

    a_pop_non_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.pop_start || i_cmd.pop_check) |-> (r_head != r_tail))
        else $error("pop started on an empty queue");

endmodule

>>> src/message_ring_queue.sv
// Message ring queue: SLOTS slots of up to SLOT_BYTES bytes each, one slot always
// kept free, so at most SLOTS-1 messages are queued. A push transaction carries one
// message byte (tuser 0); the final byte (tlast) produces the single acknowledgement:
// ok, full, or too_long. A pop transaction (tuser 1) with a capacity produces one
// empty reply, one too_small reply, or min(capacity, SLOT_BYTES) byte results
// streamed one per cycle while the output is not stalled, padded with zeros past
// the stored length. A successful pop occupies the block, which accepts no new
// transaction until it is done: it is accepted, the slot length memory is read into
// a register, then the byte memory is read once per result byte, each read
// registered before the output stage. Every result reports whether a message is
// still queued. No clearing pass runs after reset; only written slots are ever read.
module message_ring_queue #(
    parameter int SLOTS      = 8,
    parameter int SLOT_BYTES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [15:0] i_s_tdata,   // data_byte[7:0], capacity[15:8]
    input  logic        i_s_tuser,   // kind
    input  logic        i_s_tlast,   // last_byte
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // status[2:0], out_byte[10:3], message_length[16:11],
                                     // not_empty[17], zero[23:18]
    output logic        o_m_tuser,   // reply_kind
    output logic        o_m_tlast    // last_out
);

    mrq_pkg::t_cmd  cmd;
    mrq_pkg::t_stat stat;

    mrq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_kind     (i_s_tuser),
        .i_stat     (stat),
        .o_s_tready (o_s_tready),
        .o_cmd      (cmd)
    );

    mrq_dpath #(
        .SLOTS      (SLOTS),
        .SLOT_BYTES (SLOT_BYTES)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_data_byte (i_s_tdata[7:0]),
        .i_last_byte (i_s_tlast),
        .i_capacity  (i_s_tdata[15:8]),
        .i_m_tready  (i_m_tready),
        .o_m_tvalid  (o_m_tvalid),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast)
    );

endmodule
